FILE: sv/euc3d_pkg.sv
// ---------------------------------------------------------------------------
// euc3d_pkg
// Widths, constants and the root step for the 3-D distance pipeline.
// ---------------------------------------------------------------------------
package euc3d_pkg;

	localparam int unsigned COORD_W    = 16;
	localparam int unsigned NUM_COORDS = 6;
	localparam int unsigned IN_DATA_W  = COORD_W * NUM_COORDS;
	localparam int unsigned MAG_W      = 16;
	localparam int unsigned SQ_W       = 32;
	localparam int unsigned SUM_W      = 34;
	localparam int unsigned REM_W      = 32;
	localparam int unsigned SPAN_W     = 15;
	localparam int unsigned OUT_DATA_W = 16;
	localparam int unsigned ROOT_STEPS = 16;

	localparam logic [REM_W-1:0]  ROOT_FIRST_MASK = 32'h4000_0000;
	localparam logic [REM_W-1:0]  SUM_MAX         = 32'hFFFF_FFFF;
	localparam logic [SPAN_W-1:0] SPAN_MAX        = 15'h7FFF;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [SQ_W-1:0]           sq_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] root;
	} root_st_t;

	// |a - b| of two signed coordinates; fits 16 bits unsigned
	function automatic mag_t abs_diff(input coord_t a, input coord_t b);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0]        m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + 1'b1) : d;
		return m[MAG_W-1:0];
	endfunction

	// one remainder-method step with a fixed mask
	function automatic root_st_t root_step(input root_st_t cur, input logic [REM_W-1:0] mask);
		logic [REM_W:0] trial;
		logic [REM_W:0] nroot;
		root_st_t       nxt;
		trial = {1'b0, cur.root} + {1'b0, mask};
		nxt.rem = cur.rem;
		nroot = {1'b0, cur.root};
		if (trial <= {1'b0, cur.rem}) begin
			nxt.rem = cur.rem - trial[REM_W-1:0];
			nroot = trial + {1'b0, mask};
		end
		nxt.root = nroot[REM_W:1];
		return nxt;
	endfunction

endpackage

FILE: sv/euclidean_distance_3d_top.sv
// ---------------------------------------------------------------------------
// euclidean_distance_3d_top
// Rounded integer distance between two 3-D points, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//  - Input stream (s_axis_*): one beat carries two points, six signed 16-bit
//    coordinates. Output stream (m_axis_*): one beat per input beat, in order,
//    with the rounded distance saturated at 32767 and a clip flag.
//  - Stages: differences, squares, saturated sum, 16 root steps (one bit of
//    the root each), round and clip. 20 register stages in all.
//  - Throughput: one beat per cycle unless m_axis_tready holds the pipe.
//    The whole pipe advances on one enable, high while the output register
//    is empty or being drained.
//  - Stall: with m_axis_tready low and a result held, the pipe freezes and
//    s_axis_tready drops; nothing is dropped or repeated.
//  - Reset: arst_n clears all valid bits; data registers are not reset. The
//    block holds no other state and needs no setup.
// ---------------------------------------------------------------------------
module euclidean_distance_3d_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z (16 bits each)
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// span [14:0], zero pad [15]
	output logic [15:0] m_axis_tdata,
	// clipped [0]
	output logic [0:0]  m_axis_tuser
);

	localparam int unsigned CW    = euc3d_pkg::COORD_W;
	localparam int unsigned STEPS = euc3d_pkg::ROOT_STEPS;

	logic pipe_en;

	// stage 1: coordinate differences
	logic                vld_s1;
	euc3d_pkg::mag_t     dx_s1, dy_s1, dz_s1;
	// stage 2: squares
	logic                vld_s2;
	euc3d_pkg::sq_t      sqx_s2, sqy_s2, sqz_s2;
	// stages 3..19: saturated sum, then one root step per stage
	logic                          vld_s  [STEPS+1];
	euc3d_pkg::root_st_t           rt_s   [STEPS+1];
	// stage 20: output register
	logic                          vld_s20;
	logic [euc3d_pkg::SPAN_W-1:0]  span_s20;
	logic                          clip_s20;

	logic [euc3d_pkg::SUM_W-1:0]   sum_full;
	logic [euc3d_pkg::REM_W-1:0]   sum_sat;
	logic [16:0]                   root_fin;
	logic [16:0]                   root_rnd;
	logic                          clip_fin;

	assign pipe_en       = !vld_s20 || m_axis_tready;
	assign s_axis_tready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s20 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s20 <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dx_s1 <= euc3d_pkg::abs_diff(s_axis_tdata[0*CW +: CW], s_axis_tdata[3*CW +: CW]);
			dy_s1 <= euc3d_pkg::abs_diff(s_axis_tdata[1*CW +: CW], s_axis_tdata[4*CW +: CW]);
			dz_s1 <= euc3d_pkg::abs_diff(s_axis_tdata[2*CW +: CW], s_axis_tdata[5*CW +: CW]);
			sqx_s2 <= euc3d_pkg::sq_t'(dx_s1) * euc3d_pkg::sq_t'(dx_s1);
			sqy_s2 <= euc3d_pkg::sq_t'(dy_s1) * euc3d_pkg::sq_t'(dy_s1);
			sqz_s2 <= euc3d_pkg::sq_t'(dz_s1) * euc3d_pkg::sq_t'(dz_s1);
		end
	end

	assign sum_full = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	assign sum_sat  = (sum_full[euc3d_pkg::SUM_W-1 -: 2] != 2'b00) ? euc3d_pkg::SUM_MAX
	                                                               : sum_full[31:0];

	// root chain head: saturated sum with an empty root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (pipe_en) begin
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rt_s[0].rem  <= sum_sat;
			rt_s[0].root <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_root
		localparam logic [euc3d_pkg::REM_W-1:0] MASK = euc3d_pkg::ROOT_FIRST_MASK >> (2 * k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (pipe_en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rt_s[k+1] <= euc3d_pkg::root_step(rt_s[k], MASK);
			end
		end
	end

	// root is at most 65535 here; round up when remainder exceeds it
	assign root_fin = rt_s[STEPS].root[16:0];
	assign root_rnd = root_fin + 17'(rt_s[STEPS].rem > rt_s[STEPS].root);
	assign clip_fin = (root_rnd > {2'b00, euc3d_pkg::SPAN_MAX});

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			span_s20 <= clip_fin ? euc3d_pkg::SPAN_MAX : root_rnd[euc3d_pkg::SPAN_W-1:0];
			clip_s20 <= clip_fin;
		end
	end

	assign m_axis_tvalid   = vld_s20;
	assign m_axis_tdata    = {1'b0, span_s20};
	assign m_axis_tuser[0] = clip_s20;

	// a clipped result always carries the saturation value
	a_clip_span: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[14:0] == euc3d_pkg::SPAN_MAX)
		else $error("clipped beat without saturated span");

	// a frozen pipe keeps its occupancy
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(vld_s1) && $stable(vld_s2) && $stable(vld_s[0])
			&& $stable(vld_s[STEPS]) && $stable(vld_s20))
		else $error("pipeline occupancy changed during stall");

	// the root stage feeding the output never exceeds 16 bits
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[STEPS] |-> rt_s[STEPS].root[31:16] == 16'h0000)
		else $error("root out of range");

endmodule
